// ===== rtl/core/apu_pkg.sv =====
// Shared constants, types and helpers of the AdaGrad parameter update unit.
package apu_pkg;

  localparam int ELEMENTS  = 4096;
  localparam int IDX_W     = 12;
  localparam int ADDR_W    = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int ROOT_W    = 32;
  localparam int DEN_W     = 34;
  localparam int QUO_W     = 34;
  localparam int NUM_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd2;

  localparam logic [DATA_W-1:0] STEP_SIZE_RESET    = 32'd655;
  localparam logic [DATA_W-1:0] EPSILON_RESET      = 32'd1;
  localparam logic [DATA_W-1:0] DECAY_FACTOR_RESET = 32'd0;

  // Pipeline positions, counted in register sets after the input edge.
  localparam int SET_ACC  = 3;
  localparam int SET_ROOT = SET_ACC + ROOT_W - 1;
  localparam int SET_DEN  = SET_ROOT + 1;
  localparam int SET_QUO  = SET_DEN + QUO_W + 1;

  localparam logic [QUO_W-1:0] STEP_MAX = QUO_W'(64'd1 << 33);

  typedef struct packed {
    logic                     v;
    logic signed [DATA_W-1:0] p;
    logic signed [DATA_W-1:0] g;
    logic                     dz;
  } apu_side_t;

  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic [ACC_W-1:0] acc;
  } apu_fwd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -65'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

endpackage

// ===== rtl/core/apu_if.sv =====
// Valid/ready channel interfaces for parameter words and update words.
interface apu_in_if;
  import apu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         element_index;
  logic signed [DATA_W-1:0] param_value;
  logic signed [DATA_W-1:0] grad_value;
  modport source (output valid, element_index, param_value, grad_value, input ready);
  modport sink (input valid, element_index, param_value, grad_value, output ready);
endinterface

interface apu_out_if;
  import apu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_param;
  logic signed [DATA_W-1:0] decayed_grad;
  modport source (output valid, new_param, decayed_grad, input ready);
  modport sink (input valid, new_param, decayed_grad, output ready);
endinterface

// ===== rtl/core/apu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module apu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/core/apu_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module apu_isqrt
  import apu_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);
  localparam int REM_W = ROOT_W + 4;

  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [REM_W-1:0]    sh;
    logic [REM_W-1:0]    trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign sh    = {rem_in[REM_W-3:0], rad_in[2*ROOT_W-1-2*i -: 2]};
    assign trial = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i] <= rad_in;
        if (sh >= trial) begin
          rem_q[i]  <= sh - trial;
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= sh;
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[ROOT_W-1];
endmodule

// ===== rtl/core/apu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module apu_div
  import apu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W-1:0]  quo,
  output logic              over
);
  logic [DEN_W-1:0] r_p;
  logic [QUO_W-1:0] lo_p;
  logic [DEN_W-1:0] d_p;
  logic             ov_p;

  logic [DEN_W-1:0] r_q  [QUO_W];
  logic [QUO_W-1:0] q_q  [QUO_W];
  logic [QUO_W-1:0] lo_q [QUO_W];
  logic [DEN_W-1:0] d_q  [QUO_W];
  logic             ov_q [QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      r_p  <= DEN_W'(num[NUM_W-1:QUO_W]);
      lo_p <= num[QUO_W-1:0];
      d_p  <= den;
      ov_p <= (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DEN_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] d_in;
    logic             ov_in;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;

    if (j == 0) begin : g_first
      assign r_in  = r_p;
      assign q_in  = '0;
      assign lo_in = lo_p;
      assign d_in  = d_p;
      assign ov_in = ov_p;
    end else begin : g_next
      assign r_in  = r_q[j-1];
      assign q_in  = q_q[j-1];
      assign lo_in = lo_q[j-1];
      assign d_in  = d_q[j-1];
      assign ov_in = ov_q[j-1];
    end

    assign sh   = {r_in, lo_in[QUO_W-1-j]};
    assign diff = sh - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        lo_q[j] <= lo_in;
        d_q[j]  <= d_in;
        ov_q[j] <= ov_in;
        if (sh >= {1'b0, d_in}) begin
          r_q[j] <= diff[DEN_W-1:0];
          q_q[j] <= {q_in[QUO_W-2:0], 1'b1};
        end else begin
          r_q[j] <= sh[DEN_W-1:0];
          q_q[j] <= {q_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo  = q_q[QUO_W-1];
  assign over = ov_q[QUO_W-1];
endmodule

// ===== rtl/core/adagrad_param_update_unit.sv =====
// AdaGrad parameter update unit: top level with accumulator memory and pipeline.
//
//   channel  | direction | word
//   elem     | in        | element_index, param_value, grad_value
//   update   | out       | new_param, decayed_grad
//   cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One word is accepted per cycle while the output register is free or being drained.
// The pipeline depth is set mostly by the bit-per-stage square root and divider pipelines.
// After reset a clearing pass zeroes the 4096 accumulator entries, one per cycle,
// and elem.ready stays low until the pass has ended.
// The whole pipeline advances together whenever the output register is free or drained.
module adagrad_param_update_unit
  import apu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  apu_in_if.sink               elem,
  apu_out_if.source            update
);
  logic [DATA_W-1:0] step_size;
  logic [DATA_W-1:0] epsilon;
  logic [DATA_W-1:0] decay_factor;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              en;
  logic              take;

  logic                     v0;
  logic [IDX_W-1:0]         idx0;
  logic signed [DATA_W-1:0] p0;
  logic signed [DATA_W-1:0] g0;
  logic signed [64:0]       prod0;
  logic signed [64:0]       gsum0;

  logic                     v1;
  logic [IDX_W-1:0]         idx1;
  logic signed [DATA_W-1:0] p1;
  logic signed [DATA_W-1:0] g1;
  logic [ACC_W-1:0]         ramq1;
  logic [ACC_W-1:0]         ram_rdata;

  logic                     v2;
  logic [IDX_W-1:0]         idx2;
  logic signed [DATA_W-1:0] p2;
  logic signed [DATA_W-1:0] g2;
  logic [ACC_W-1:0]         ramq2;
  logic [ACC_W-1:0]         sq2;
  logic [DATA_W-1:0]        mag1;
  logic [2*DATA_W-1:0]      sqfull;

  logic                     inr2;
  logic [ACC_W-1:0]         base2;
  logic [ACC_W:0]           sum2;
  logic [ACC_W-1:0]         acc_next;
  apu_fwd_t                 hist [3];

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ACC_W-1:0]         ram_wdata;

  apu_side_t                sb [SET_ACC:SET_QUO];
  logic [ROOT_W-1:0]        root;
  logic [DEN_W-1:0]         den;
  logic [NUM_W-1:0]         lrm;
  logic [QUO_W-1:0]         quo;
  logic                     over;
  logic [QUO_W-1:0]         step;
  logic signed [64:0]       np_wide;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= STEP_SIZE_RESET;
      epsilon      <= EPSILON_RESET;
      decay_factor <= DECAY_FACTOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_SIZE:    step_size    <= cfg_data;
        REG_EPSILON:      epsilon      <= cfg_data;
        REG_DECAY_FACTOR: decay_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass over the accumulator memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign en         = !update.valid || update.ready;
  assign elem.ready = en && !clearing;
  assign take       = elem.valid && elem.ready;

  // Set 0: capture the word and form the decay product.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0  <= elem.element_index;
      p0    <= elem.param_value;
      g0    <= elem.grad_value;
      prod0 <= $signed({1'b0, decay_factor}) * elem.param_value;
    end
  end

  // Set 1: decayed gradient.
  assign gsum0 = $signed({{33{g0[DATA_W-1]}}, g0}) + (prod0 >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1  <= idx0;
      p1    <= p0;
      g1    <= (decay_factor != '0) ? sat32(gsum0) : g0;
      ramq1 <= ram_rdata;
    end
  end

  // Set 2: squared gradient.
  assign mag1   = abs32(g1);
  assign sqfull = 64'(mag1) * 64'(mag1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx2  <= idx1;
      p2    <= p1;
      g2    <= g1;
      ramq2 <= ramq1;
      sq2   <= sqfull[FRAC_W +: ACC_W];
    end
  end

  // Accumulate with forwarding from the three newer writes not seen by the read.
  assign inr2 = ({1'b0, idx2} < (IDX_W + 1)'(ELEMENTS));

  always_comb begin
    if (!inr2) begin
      base2 = '0;
    end else if (hist[0].wr && hist[0].idx == idx2) begin
      base2 = hist[0].acc;
    end else if (hist[1].wr && hist[1].idx == idx2) begin
      base2 = hist[1].acc;
    end else if (hist[2].wr && hist[2].idx == idx2) begin
      base2 = hist[2].acc;
    end else begin
      base2 = ramq2;
    end
  end

  assign sum2     = {1'b0, base2} + {1'b0, sq2};
  assign acc_next = sum2[ACC_W] ? '1 : sum2[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0].wr <= 1'b0;
      hist[1].wr <= 1'b0;
      hist[2].wr <= 1'b0;
    end else if (en) begin
      hist[0].wr  <= v2 && inr2;
      hist[0].idx <= idx2;
      hist[0].acc <= acc_next;
      hist[1]     <= hist[0];
      hist[2]     <= hist[1];
    end
  end

  assign ram_we    = clearing || (en && v2 && inr2);
  assign ram_waddr = clearing ? clr_addr : idx2[ADDR_W-1:0];
  assign ram_wdata = clearing ? '0 : acc_next;

  apu_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ELEMENTS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (elem.element_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Root of the accumulator scaled to Q16.16.
  apu_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({acc_next, FRAC_W'(0)}),
    .root     (root)
  );

  // Sideband line carrying each word alongside the arithmetic units.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = SET_ACC; k <= SET_QUO; k++) begin
        sb[k].v <= 1'b0;
      end
    end else if (en) begin
      sb[SET_ACC].v  <= v2;
      sb[SET_ACC].p  <= p2;
      sb[SET_ACC].g  <= g2;
      sb[SET_ACC].dz <= 1'b0;
      for (int k = SET_ACC + 1; k <= SET_QUO; k++) begin
        sb[k].v <= sb[k-1].v;
        sb[k].p <= sb[k-1].p;
        sb[k].g <= sb[k-1].g;
        if (k == SET_DEN) begin
          sb[k].dz <= (root == '0) && (epsilon == '0);
        end else begin
          sb[k].dz <= sb[k-1].dz;
        end
      end
    end
  end

  // Denominator and scaled numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      den <= DEN_W'(root) + DEN_W'(epsilon);
      lrm <= NUM_W'(step_size) * NUM_W'(abs32(sb[SET_ROOT].g));
    end
  end

  apu_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (lrm),
    .den  (den),
    .quo  (quo),
    .over (over)
  );

  // Final update and output register.
  assign step    = (over || quo > STEP_MAX) ? STEP_MAX : quo;
  assign np_wide = sb[SET_QUO].g[DATA_W-1]
                 ? {{33{sb[SET_QUO].p[DATA_W-1]}}, sb[SET_QUO].p} + {31'b0, step}
                 : {{33{sb[SET_QUO].p[DATA_W-1]}}, sb[SET_QUO].p} - {31'b0, step};

  always_ff @(posedge clk) begin
    if (rst) begin
      update.valid <= 1'b0;
    end else if (en) begin
      update.valid <= sb[SET_QUO].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      update.decayed_grad <= sb[SET_QUO].g;
      update.new_param    <= sb[SET_QUO].dz ? sb[SET_QUO].p : sat32(np_wide);
    end
  end

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !elem.ready)
    else $error("word accepted during clearing pass");

  a_no_pipe_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(v2 || hist[0].wr || sb[SET_ACC].v))
    else $error("pipeline holds words during clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (clearing && clr_addr == ADDR_W'(ELEMENTS - 1)) |=> !clearing)
    else $error("clearing pass did not end at the last entry");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (!en && !$past(rst)) |=> ($stable(v2) && $stable(hist[0].wr) && $stable(sb[SET_QUO].v)))
    else $error("pipeline moved while stalled");
endmodule

// ===== bench/adagrad_param_update_unit_test.sv =====
// Self-checking bench for the AdaGrad parameter update unit, with stalls and config phases.
module adagrad_param_update_unit_test;
  import apu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] param;
    logic signed [DATA_W-1:0] grad;
  } elem_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] new_param;
    logic signed [DATA_W-1:0] decayed_grad;
  } update_word_t;

  localparam logic [63:0] SUM_MAX = (64'd1 << 48) - 64'd1;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  apu_in_if  elem_ch ();
  apu_out_if update_ch ();

  adagrad_param_update_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .elem(elem_ch.sink), .update(update_ch.source)
  );

  always #6 clk = ~clk;

  logic [ACC_W-1:0] grad_sq_sum [ELEMENTS];
  logic [DATA_W-1:0] lr_q, eps_q, wd_q;

  elem_word_t   pending_words[$];
  update_word_t expected_updates[$];
  elem_word_t   offered;
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;

  function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic update_word_t adagrad_update(elem_word_t w);
    update_word_t r;
    logic signed [63:0] pe, we, gd, np;
    logic [63:0] mag, sq, acc, v, root, bitv, den, stp;
    pe = w.param;
    gd = w.grad;
    if (wd_q != 0) begin
      we = {32'd0, wd_q};
      gd = clamp32(gd + ((we * pe) >>> 16));
    end
    mag = (gd < 0) ? -gd : gd;
    sq = (mag * mag) >> 16;
    acc = {16'd0, grad_sq_sum[w.idx]};
    acc = (acc > SUM_MAX - sq) ? SUM_MAX : acc + sq;
    grad_sq_sum[w.idx] = acc[ACC_W-1:0];
    v = acc << 16;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    den = root + {32'd0, eps_q};
    if (den == 0) begin
      np = pe;
    end else begin
      stp = ({32'd0, lr_q} * mag) / den;
      if (stp > (64'd1 << 33)) stp = 64'd1 << 33;
      np = (gd < 0) ? pe + $signed(stp) : pe - $signed(stp);
      np = clamp32(np);
    end
    r.new_param = np[DATA_W-1:0];
    r.decayed_grad = gd[DATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      elem_ch.valid <= 1'b0;
    end else begin
      if (elem_ch.valid && elem_ch.ready) begin
        expected_updates.push_back(adagrad_update(offered));
      end
      if (!elem_ch.valid || elem_ch.ready) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
          offered = pending_words.pop_front();
          elem_ch.element_index <= offered.idx;
          elem_ch.param_value <= offered.param;
          elem_ch.grad_value <= offered.grad;
          elem_ch.valid <= 1'b1;
        end else begin
          elem_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    update_word_t want;
    if (rst) begin
      update_ch.ready <= 1'b0;
    end else begin
      if (update_ch.valid && update_ch.ready) begin
        if (expected_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected update word: new_param %h decayed_grad %h",
                                         update_ch.new_param, update_ch.decayed_grad);
        end else begin
          want = expected_updates.pop_front();
          if (want.new_param !== update_ch.new_param ||
              want.decayed_grad !== update_ch.decayed_grad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: new_param exp %h got %h, decayed_grad exp %h got %h",
                       want.new_param, update_ch.new_param,
                       want.decayed_grad, update_ch.decayed_grad);
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        update_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_cnt <= 400;
        update_ch.ready <= 1'b0;
      end else begin
        update_ch.ready <= quiet || $urandom_range(99) >= 33;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_word(int idx, logic [31:0] p, logic [31:0] g);
    elem_word_t w;
    w.idx = idx[IDX_W-1:0];
    w.param = p;
    w.grad = g;
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(0, 131071) - 65536;
      1: return 32'h7FFFFFFF - $urandom_range(3);
      2: return 32'h80000000 + $urandom_range(3);
      3: return $urandom_range(0, 16777215) - 8388608;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || elem_ch.valid || expected_updates.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_SIZE:    lr_q = val;
      REG_EPSILON:      eps_q = val;
      REG_DECAY_FACTOR: wd_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int idx;
    for (int i = 0; i < count; i++) begin
      idx = ($urandom_range(3) == 0) ? $urandom_range(ELEMENTS - 1) : $urandom_range(15);
      add_word(idx, pick_value(), pick_value());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    elem_ch.valid = 1'b0;
    elem_ch.element_index = '0;
    elem_ch.param_value = '0;
    elem_ch.grad_value = '0;
    update_ch.ready = 1'b0;
    for (int i = 0; i < ELEMENTS; i++) grad_sq_sum[i] = '0;
    lr_q = STEP_SIZE_RESET;
    eps_q = EPSILON_RESET;
    wd_q = DECAY_FACTOR_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_word(0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_word(4095, 32'h80000000, 32'h80000000);
    add_word(1, 32'h00010000, 32'h00000000);
    add_word(2, 32'hFFFF0000, 32'h00010000);
    add_word(3, 32'h00000000, 32'hFFFFFFFF);
    for (int i = 0; i < 6; i++) add_word(7, 32'h80000000, 32'h80000000);
    for (int i = 0; i < 6; i++) add_word(8, 32'h7FFFFFFF, 32'h7FFFFFFF);
    wait_idle();

    write_reg(REG_STEP_SIZE, 32'hFFFFFFFF);
    write_reg(REG_EPSILON, 32'h00000000);
    write_reg(REG_DECAY_FACTOR, 32'h00000000);
    add_word(4000, 32'h12345678, 32'h00000000);
    add_word(4001, 32'h80000000, 32'h00000001);
    add_word(4002, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add_word(4003, 32'h00000000, 32'h7FFFFFFF);
    add_word(4003, 32'h00000000, 32'h80000000);
    random_phase(150);
    hold_req <= 1'b1;
    wait_idle();

    write_reg(REG_STEP_SIZE, $urandom);
    write_reg(REG_EPSILON, $urandom_range(65535));
    write_reg(REG_DECAY_FACTOR, $urandom_range(65536));
    quiet = 1'b1;
    random_phase(250);
    wait_idle();
    quiet = 1'b0;

    write_reg(REG_STEP_SIZE, 32'h00000000);
    write_reg(REG_EPSILON, 32'hFFFFFFFF);
    write_reg(REG_DECAY_FACTOR, 32'hFFFFFFFF);
    random_phase(250);
    wait_idle();

    write_reg(REG_STEP_SIZE, $urandom);
    write_reg(REG_EPSILON, $urandom);
    write_reg(REG_DECAY_FACTOR, $urandom);
    random_phase(300);
    wait_idle();

    write_reg(REG_STEP_SIZE, 32'h00010000);
    write_reg(REG_EPSILON, 32'h00000001);
    write_reg(REG_DECAY_FACTOR, 32'h00000000);
    random_phase(350);
    wait_idle();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
